// ----- hw/rtl/fern_regressor_apply_macros.svh -----
// Assertion macros shared by the fern regressor RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef FERN_REGRESSOR_APPLY_MACROS_SVH
`define FERN_REGRESSOR_APPLY_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FRA_ASSERT_IMP(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FRA_ASSERT_NXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- hw/rtl/fra_pkg.sv -----
// Shared types and constants for the fern regressor.
// No dependencies; imported by every RTL module of the block.
package fra_pkg;

    localparam int MAX_TESTS_DEF     = 5;
    localparam int FEATURE_COUNT_DEF = 512;
    localparam int COEF_COUNT_DEF    = 256;
    localparam int MAX_ENTRIES_DEF   = 16;

    localparam int MODE_W    = 3;
    localparam int SLOT_W    = 3;
    localparam int FADDR_W   = 9;
    localparam int FEAT_W    = 16;
    localparam int THR_W     = 17;
    localparam int BIN_IN_W  = 5;
    localparam int ESLOT_W   = 4;
    localparam int CIDX_W    = 8;
    localparam int COEF_W    = 32;
    localparam int LEN_IN_W  = 5;
    localparam int BIN_OUT_W = 5;
    localparam int CFG_W     = 3;

    localparam int TESTS_RESET = 5;

    localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    typedef enum logic [MODE_W-1:0] {
        MODE_FEATURE = 3'd0,
        MODE_TEST    = 3'd1,
        MODE_ENTRY   = 3'd2,
        MODE_LENGTH  = 3'd3,
        MODE_COEF_WR = 3'd4,
        MODE_APPLY   = 3'd5,
        MODE_COEF_RD = 3'd6
    } fra_mode_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } fra_alu_op_t;

    typedef struct packed {
        fra_alu_op_t              op;
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
    } fra_alu_req_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] res;
        logic                     sat;
        logic                     pos;
    } fra_alu_rsp_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_TA,
        S_TB,
        S_TDIFF,
        S_TCMP,
        S_LEN,
        S_EREAD,
        S_EWAIT,
        S_ESUM
    } fra_state_t;

endpackage

// ----- hw/rtl/fra_alu.sv -----
// Shared add/subtract unit with 32-bit saturation and a positive flag.
// Depends on fra_pkg for the request and response structs.
module fra_alu (
    input  fra_pkg::fra_alu_req_t req,
    output fra_pkg::fra_alu_rsp_t rsp
);
    import fra_pkg::*;

    logic signed [COEF_W:0] a_ext;
    logic signed [COEF_W:0] b_ext;
    logic signed [COEF_W:0] sum;
    logic                   ovf;

    always_comb
    begin
        a_ext = {req.a[COEF_W-1], req.a};
        b_ext = {req.b[COEF_W-1], req.b};
        sum   = (req.op == ALU_SUB) ? (a_ext - b_ext) : (a_ext + b_ext);
        ovf   = (sum[COEF_W] != sum[COEF_W-1]);
        rsp.pos = !sum[COEF_W] && (sum != '0);
        rsp.sat = ovf;
        if (ovf)
        begin
            // clip toward the side the true sum lies on
            rsp.res = sum[COEF_W] ? COEF_MIN : COEF_MAX;
        end
        else
        begin
            rsp.res = sum[COEF_W-1:0];
        end
    end

endmodule

// ----- hw/rtl/fra_seq.sv -----
// Sequencer and stores of the fern regressor: loads, fern tests, list walk.
// Depends on fra_pkg and on the assertion macros header; drives fra_alu.
`include "fern_regressor_apply_macros.svh"

module fra_seq #(
    parameter int MAX_TESTS     = fra_pkg::MAX_TESTS_DEF,
    parameter int FEATURE_COUNT = fra_pkg::FEATURE_COUNT_DEF,
    parameter int COEF_COUNT    = fra_pkg::COEF_COUNT_DEF,
    parameter int MAX_ENTRIES   = fra_pkg::MAX_ENTRIES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [$clog2(MAX_TESTS+1)-1:0]        n_tests,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [fra_pkg::MODE_W-1:0]            mode,
    input  logic [fra_pkg::SLOT_W-1:0]            test_slot,
    input  logic [fra_pkg::FADDR_W-1:0]           first_feature,
    input  logic [fra_pkg::FADDR_W-1:0]           second_feature,
    input  logic signed [fra_pkg::FEAT_W-1:0]     feature_value,
    input  logic signed [fra_pkg::THR_W-1:0]      threshold,
    input  logic [fra_pkg::BIN_IN_W-1:0]          bin,
    input  logic [fra_pkg::ESLOT_W-1:0]           entry_slot,
    input  logic [fra_pkg::CIDX_W-1:0]            coef_index,
    input  logic signed [fra_pkg::COEF_W-1:0]     coef_value,
    input  logic [fra_pkg::LEN_IN_W-1:0]          list_length,
    output fra_pkg::fra_alu_req_t                 alu_req,
    input  fra_pkg::fra_alu_rsp_t                 alu_rsp,
    output logic                                  done,
    output logic [fra_pkg::BIN_OUT_W-1:0]         bin_index,
    output logic signed [fra_pkg::COEF_W-1:0]     read_value,
    output logic                                  saturated
);
    import fra_pkg::*;

    localparam int BIN_COUNT = 1 << MAX_TESTS;
    localparam int BW        = MAX_TESTS;
    localparam int TI_W      = (MAX_TESTS > 1) ? $clog2(MAX_TESTS) : 1;
    localparam int FA_W      = $clog2(FEATURE_COUNT);
    localparam int CA_W      = (COEF_COUNT > 1) ? $clog2(COEF_COUNT) : 1;
    localparam int ENT_DEPTH = BIN_COUNT * MAX_ENTRIES;
    localparam int EA_W      = $clog2(ENT_DEPTH);
    localparam int LW        = $clog2(MAX_ENTRIES + 1);
    localparam int CLR_DEPTH = (COEF_COUNT > BIN_COUNT) ? COEF_COUNT : BIN_COUNT;
    localparam int CLR_W     = $clog2(CLR_DEPTH);
    localparam int ENT_W     = CIDX_W + COEF_W;
    localparam int DIFF_W    = FEAT_W + 1;

    // control state
    fra_state_t          state_reg, state_next;
    logic [TI_W-1:0]     i_reg, i_next;
    logic [LW-1:0]       k_reg, k_next;
    logic [BW-1:0]       bin_reg, bin_next;
    logic                sat_reg, sat_next;
    logic [CLR_W-1:0]    clr_reg, clr_next;
    logic                done_reg, done_next;
    logic [BW-1:0]       bin_out_reg, bin_out_next;
    logic                sat_out_reg, sat_out_next;
    logic                rd_sel_reg, rd_sel_next;

    // operand holding
    logic signed [FEAT_W-1:0] opa_reg, opa_next;
    logic signed [DIFF_W-1:0] diff_reg, diff_next;
    logic                     a_ok_reg, a_ok_next;
    logic                     b_ok_reg, b_ok_next;
    logic [CA_W-1:0]          idx_reg, idx_next;
    logic signed [COEF_W-1:0] delta_reg, delta_next;

    // test stores
    logic [FADDR_W-1:0]       test_first_reg  [MAX_TESTS];
    logic [FADDR_W-1:0]       test_second_reg [MAX_TESTS];
    logic signed [THR_W-1:0]  thr_reg         [MAX_TESTS];
    logic                     test_we;

    // memories
    logic signed [FEAT_W-1:0] feat_ram_reg [FEATURE_COUNT];
    logic [ENT_W-1:0]         ent_ram_reg  [ENT_DEPTH];
    logic [LW-1:0]            len_ram_reg  [BIN_COUNT];
    logic signed [COEF_W-1:0] coef_ram_reg [COEF_COUNT];
    logic signed [FEAT_W-1:0] feat_q_reg;
    logic [ENT_W-1:0]         ent_q_reg;
    logic [LW-1:0]            len_q_reg;
    logic signed [COEF_W-1:0] coef_q_reg;

    logic                     feat_we;
    logic [FA_W-1:0]          feat_raddr;
    logic                     ent_we;
    logic [EA_W-1:0]          ent_raddr;
    logic                     len_we;
    logic [BW-1:0]            len_waddr;
    logic [LW-1:0]            len_wdata;
    logic                     coef_we;
    logic [CA_W-1:0]          coef_waddr;
    logic signed [COEF_W-1:0] coef_wdata;
    logic [CA_W-1:0]          coef_raddr;

    // widened views of the beat fields and counters
    logic        accept;
    logic [31:0] slot_w, fa_w, fb_w, bin_w, eslot_w, ci_w, len_in_w, clr_w;
    logic [31:0] test_a_w, test_b_w, ent_waddr_w, ent_raddr_w, ent_idx_w, bin_out_w;
    logic [LW-1:0] len_sat;
    logic signed [FEAT_W-1:0] b_val;

    assign accept      = start && !busy;
    assign slot_w      = 32'(test_slot);
    assign fa_w        = 32'(first_feature);
    assign fb_w        = 32'(second_feature);
    assign bin_w       = 32'(bin);
    assign eslot_w     = 32'(entry_slot);
    assign ci_w        = 32'(coef_index);
    assign len_in_w    = 32'(list_length);
    assign clr_w       = 32'(clr_reg);
    assign test_a_w    = 32'(test_first_reg[i_reg]);
    assign test_b_w    = 32'(test_second_reg[i_reg]);
    assign ent_waddr_w = bin_w * MAX_ENTRIES + eslot_w;
    assign ent_raddr_w = 32'(bin_reg) * MAX_ENTRIES + 32'(k_reg);
    assign ent_idx_w   = 32'(ent_q_reg[ENT_W-1:COEF_W]);
    assign bin_out_w   = 32'(bin_out_reg);
    assign len_sat     = (len_in_w > MAX_ENTRIES) ? LW'(MAX_ENTRIES) : LW'(list_length);
    assign b_val       = b_ok_reg ? feat_q_reg : '0;

    always_comb
    begin
        state_next   = state_reg;
        i_next       = i_reg;
        k_next       = k_reg;
        bin_next     = bin_reg;
        sat_next     = sat_reg;
        clr_next     = clr_reg;
        done_next    = 1'b0;
        bin_out_next = bin_out_reg;
        sat_out_next = sat_out_reg;
        rd_sel_next  = 1'b0;
        opa_next     = opa_reg;
        diff_next    = diff_reg;
        a_ok_next    = a_ok_reg;
        b_ok_next    = b_ok_reg;
        idx_next     = idx_reg;
        delta_next   = delta_reg;

        test_we    = 1'b0;
        feat_we    = 1'b0;
        feat_raddr = test_a_w[FA_W-1:0];
        ent_we     = 1'b0;
        ent_raddr  = ent_raddr_w[EA_W-1:0];
        len_we     = 1'b0;
        len_waddr  = bin_w[BW-1:0];
        len_wdata  = len_sat;
        coef_we    = 1'b0;
        coef_waddr = ci_w[CA_W-1:0];
        coef_wdata = coef_value;
        coef_raddr = ci_w[CA_W-1:0];

        alu_req.op = ALU_SUB;
        alu_req.a  = COEF_W'(opa_reg);
        alu_req.b  = COEF_W'(b_val);

        case (state_reg)
            S_CLEAR:
            begin
                // sweep the coefficient and list length memories after reset
                coef_we    = (clr_w < COEF_COUNT);
                coef_waddr = clr_w[CA_W-1:0];
                coef_wdata = '0;
                len_we     = (clr_w < BIN_COUNT);
                len_waddr  = clr_w[BW-1:0];
                len_wdata  = '0;
                if (clr_w == CLR_DEPTH - 1)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    done_next    = 1'b1;
                    bin_out_next = '0;
                    sat_out_next = 1'b0;
                    case (fra_mode_t'(mode))
                        MODE_FEATURE: feat_we = (fa_w < FEATURE_COUNT);
                        MODE_TEST:    test_we = (slot_w < MAX_TESTS);
                        MODE_ENTRY:   ent_we  = (bin_w < BIN_COUNT) && (eslot_w < MAX_ENTRIES);
                        MODE_LENGTH:  len_we  = (bin_w < BIN_COUNT);
                        MODE_COEF_WR: coef_we = (ci_w < COEF_COUNT);
                        MODE_COEF_RD: rd_sel_next = (ci_w < COEF_COUNT);
                        MODE_APPLY:
                        begin
                            done_next  = 1'b0;
                            bin_next   = '0;
                            sat_next   = 1'b0;
                            i_next     = '0;
                            state_next = (n_tests == '0) ? S_LEN : S_TA;
                        end
                        default: ;
                    endcase
                end
            end
            S_TA:
            begin
                feat_raddr = test_a_w[FA_W-1:0];
                a_ok_next  = (test_a_w < FEATURE_COUNT);
                state_next = S_TB;
            end
            S_TB:
            begin
                feat_raddr = test_b_w[FA_W-1:0];
                b_ok_next  = (test_b_w < FEATURE_COUNT);
                opa_next   = a_ok_reg ? feat_q_reg : '0;
                state_next = S_TDIFF;
            end
            S_TDIFF:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = COEF_W'(opa_reg);
                alu_req.b  = COEF_W'(b_val);
                diff_next  = alu_rsp.res[DIFF_W-1:0];
                state_next = S_TCMP;
            end
            S_TCMP:
            begin
                alu_req.op      = ALU_SUB;
                alu_req.a       = COEF_W'(diff_reg);
                alu_req.b       = COEF_W'(thr_reg[i_reg]);
                bin_next[i_reg] = alu_rsp.pos;
                if (32'(i_reg) + 32'd1 >= 32'(n_tests))
                begin
                    state_next = S_LEN;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_TA;
                end
            end
            S_LEN:
            begin
                // list length of the final bin lands next cycle
                k_next     = '0;
                state_next = S_EREAD;
            end
            S_EREAD:
            begin
                if (k_reg < len_q_reg)
                begin
                    state_next = S_EWAIT;
                end
                else
                begin
                    done_next    = 1'b1;
                    bin_out_next = bin_reg;
                    sat_out_next = sat_reg;
                    state_next   = S_IDLE;
                end
            end
            S_EWAIT:
            begin
                if (ent_idx_w < COEF_COUNT)
                begin
                    coef_raddr = ent_idx_w[CA_W-1:0];
                    idx_next   = ent_idx_w[CA_W-1:0];
                    delta_next = ent_q_reg[COEF_W-1:0];
                    state_next = S_ESUM;
                end
                else
                begin
                    // drop entries that point past the coefficient store
                    k_next     = k_reg + 1'b1;
                    state_next = S_EREAD;
                end
            end
            S_ESUM:
            begin
                alu_req.op = ALU_ADD;
                alu_req.a  = coef_q_reg;
                alu_req.b  = delta_reg;
                coef_we    = 1'b1;
                coef_waddr = idx_reg;
                coef_wdata = alu_rsp.res;
                sat_next   = sat_reg | alu_rsp.sat;
                k_next     = k_reg + 1'b1;
                state_next = S_EREAD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            i_reg       <= '0;
            k_reg       <= '0;
            bin_reg     <= '0;
            sat_reg     <= 1'b0;
            clr_reg     <= '0;
            done_reg    <= 1'b0;
            bin_out_reg <= '0;
            sat_out_reg <= 1'b0;
            rd_sel_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            k_reg       <= k_next;
            bin_reg     <= bin_next;
            sat_reg     <= sat_next;
            clr_reg     <= clr_next;
            done_reg    <= done_next;
            bin_out_reg <= bin_out_next;
            sat_out_reg <= sat_out_next;
            rd_sel_reg  <= rd_sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opa_reg   <= opa_next;
        diff_reg  <= diff_next;
        a_ok_reg  <= a_ok_next;
        b_ok_reg  <= b_ok_next;
        idx_reg   <= idx_next;
        delta_reg <= delta_next;
    end

    always_ff @(posedge clk)
    begin
        if (test_we)
        begin
            test_first_reg[slot_w[TI_W-1:0]]  <= first_feature;
            test_second_reg[slot_w[TI_W-1:0]] <= second_feature;
            thr_reg[slot_w[TI_W-1:0]]         <= threshold;
        end
    end

    always_ff @(posedge clk)
    begin
        if (feat_we)
        begin
            feat_ram_reg[fa_w[FA_W-1:0]] <= feature_value;
        end
        feat_q_reg <= feat_ram_reg[feat_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_ram_reg[ent_waddr_w[EA_W-1:0]] <= {coef_index, coef_value};
        end
        ent_q_reg <= ent_ram_reg[ent_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_ram_reg[len_waddr] <= len_wdata;
        end
        len_q_reg <= len_ram_reg[bin_reg];
    end

    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_ram_reg[coef_waddr] <= coef_wdata;
        end
        coef_q_reg <= coef_ram_reg[coef_raddr];
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign bin_index  = bin_out_w[BIN_OUT_W-1:0];
    assign read_value = rd_sel_reg ? coef_q_reg : '0;
    assign saturated  = sat_out_reg;

    `FRA_ASSERT_NXT(a_load_beat_result, start && !busy && (mode != MODE_APPLY), done, "load or read beat gave no result")
    `FRA_ASSERT_NXT(a_apply_holds, start && !busy && (mode == MODE_APPLY), busy && !done, "apply beat did not occupy the sequencer")
    `FRA_ASSERT_IMP(a_sum_in_list, state_reg == S_ESUM, k_reg < len_q_reg, "entry summed past the end of its list")
    `FRA_ASSERT_IMP(a_read_clean, done_reg && rd_sel_reg, !sat_out_reg && (bin_out_reg == '0), "read result carries apply fields")

endmodule

// ----- hw/rtl/fern_regressor_apply.sv -----
// Top level of the fern regressor: tests_in_use register, sequencer, shared ALU.
// Depends on fra_pkg, fra_alu and fra_seq.
//
// One beat is taken when start is high and busy is low; each beat yields one result,
// shown for a single cycle with done high, and the receiver cannot hold it off.
// After reset the block sweeps its coefficient and list length memories, holding
// busy high until the sweep ends. Loads and coefficient reads leave busy low, and
// the result follows in the next cycle. An apply holds busy from the beat being
// taken until its bin is found and the list of that bin is walked; the result
// appears in the same cycle in which busy drops. Each test makes two reads through
// the one read port of the feature memory and two passes through the one shared
// adder, and each entry reads the entry memory, then, if its index lies within the
// coefficient store, reads, adds and writes back one coefficient.
// tests_in_use may be written only while no beat is in flight.
module fern_regressor_apply #(
    parameter int MAX_TESTS     = fra_pkg::MAX_TESTS_DEF,
    parameter int FEATURE_COUNT = fra_pkg::FEATURE_COUNT_DEF,
    parameter int COEF_COUNT    = fra_pkg::COEF_COUNT_DEF,
    parameter int MAX_ENTRIES   = fra_pkg::MAX_ENTRIES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [fra_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              start,
    output logic                              busy,
    input  logic [fra_pkg::MODE_W-1:0]        mode,
    input  logic [fra_pkg::SLOT_W-1:0]        test_slot,
    input  logic [fra_pkg::FADDR_W-1:0]       first_feature,
    input  logic [fra_pkg::FADDR_W-1:0]       second_feature,
    input  logic signed [fra_pkg::FEAT_W-1:0] feature_value,
    input  logic signed [fra_pkg::THR_W-1:0]  threshold,
    input  logic [fra_pkg::BIN_IN_W-1:0]      bin,
    input  logic [fra_pkg::ESLOT_W-1:0]       entry_slot,
    input  logic [fra_pkg::CIDX_W-1:0]        coef_index,
    input  logic signed [fra_pkg::COEF_W-1:0] coef_value,
    input  logic [fra_pkg::LEN_IN_W-1:0]      list_length,
    output logic                              done,
    output logic [fra_pkg::BIN_OUT_W-1:0]     bin_index,
    output logic signed [fra_pkg::COEF_W-1:0] read_value,
    output logic                              saturated
);
    import fra_pkg::*;

    localparam int NT_W = $clog2(MAX_TESTS + 1);

    logic [CFG_W-1:0] tests_reg, tests_next;
    logic [NT_W-1:0]  n_tests;
    fra_alu_req_t     alu_req;
    fra_alu_rsp_t     alu_rsp;

    assign tests_next = cfg_write ? cfg_data : tests_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tests_reg <= CFG_W'(TESTS_RESET);
        end
        else
        begin
            tests_reg <= tests_next;
        end
    end

    // clamp the register to the number of test slots built
    assign n_tests = (32'(tests_reg) > MAX_TESTS) ? NT_W'(MAX_TESTS) : NT_W'(tests_reg);

    fra_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    fra_seq #(
        .MAX_TESTS     (MAX_TESTS),
        .FEATURE_COUNT (FEATURE_COUNT),
        .COEF_COUNT    (COEF_COUNT),
        .MAX_ENTRIES   (MAX_ENTRIES)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .n_tests        (n_tests),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .test_slot      (test_slot),
        .first_feature  (first_feature),
        .second_feature (second_feature),
        .feature_value  (feature_value),
        .threshold      (threshold),
        .bin            (bin),
        .entry_slot     (entry_slot),
        .coef_index     (coef_index),
        .coef_value     (coef_value),
        .list_length    (list_length),
        .alu_req        (alu_req),
        .alu_rsp        (alu_rsp),
        .done           (done),
        .bin_index      (bin_index),
        .read_value     (read_value),
        .saturated      (saturated)
    );

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for fern_regressor_apply: a directed table, then random phases.
// Depends on fra_pkg and the fern_regressor_apply RTL; results are checked against
// an in-bench model of the fern stores and the saturating coefficient update.
module tb_top;
    import fra_pkg::*;

    localparam int N_TESTS    = MAX_TESTS_DEF;
    localparam int N_FEATURES = FEATURE_COUNT_DEF;
    localparam int N_COEFS    = COEF_COUNT_DEF;
    localparam int N_ENTRIES  = MAX_ENTRIES_DEF;
    localparam int N_BINS     = 1 << N_TESTS;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 100;
    localparam int PHASE_BEATS = 200;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

    typedef struct {
        logic [MODE_W-1:0]        mode;
        logic [SLOT_W-1:0]        slot;
        logic [FADDR_W-1:0]       fa;
        logic [FADDR_W-1:0]       fb;
        logic signed [FEAT_W-1:0] fval;
        logic signed [THR_W-1:0]  thr;
        logic [BIN_IN_W-1:0]      bin;
        logic [ESLOT_W-1:0]       eslot;
        logic [CIDX_W-1:0]        ci;
        logic signed [COEF_W-1:0] cval;
        logic [LEN_IN_W-1:0]      len;
    } fern_cmd_t;

    typedef struct {
        logic [BIN_OUT_W-1:0]     bin_index;
        logic signed [COEF_W-1:0] read_value;
        logic                     saturated;
    } fern_res_t;

    typedef struct {
        bit              is_cfg;
        logic [CFG_W-1:0] cfg;
        fern_cmd_t       cmd;
        bit              typed;
        fern_res_t       res;
    } table_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_write;
    logic [CFG_W-1:0]          cfg_data;
    logic                      start;
    logic                      busy;
    logic [MODE_W-1:0]         mode;
    logic [SLOT_W-1:0]         test_slot;
    logic [FADDR_W-1:0]        first_feature;
    logic [FADDR_W-1:0]        second_feature;
    logic signed [FEAT_W-1:0]  feature_value;
    logic signed [THR_W-1:0]   threshold;
    logic [BIN_IN_W-1:0]       bin;
    logic [ESLOT_W-1:0]        entry_slot;
    logic [CIDX_W-1:0]         coef_index;
    logic signed [COEF_W-1:0]  coef_value;
    logic [LEN_IN_W-1:0]       list_length;
    logic                      done;
    logic [BIN_OUT_W-1:0]      bin_index;
    logic signed [COEF_W-1:0]  read_value;
    logic                      saturated;

    // Model state of the fern
    bit [CFG_W-1:0]          tests_cfg = CFG_W'(TESTS_RESET);
    bit signed [FEAT_W-1:0]  feat_mem [N_FEATURES];
    bit [FADDR_W-1:0]        test_a [N_TESTS];
    bit [FADDR_W-1:0]        test_b [N_TESTS];
    bit signed [THR_W-1:0]   thr_mem [N_TESTS];
    bit [LEN_IN_W-1:0]       len_mem [N_BINS];
    bit [CIDX_W-1:0]         ent_idx [N_BINS*N_ENTRIES];
    bit signed [COEF_W-1:0]  ent_delta [N_BINS*N_ENTRIES];
    bit signed [COEF_W-1:0]  coef_mem [N_COEFS];

    // Which undefined-at-reset entries hold data
    bit feat_wr [N_FEATURES];
    bit test_wr [N_TESTS];
    bit ent_wr [N_BINS*N_ENTRIES];

    fern_res_t  results_due [$];
    fern_res_t  oldest_due;
    table_row_t steps [$];
    int         errors = 0;
    int         stall_cycles = 0;

    fern_regressor_apply DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .test_slot      (test_slot),
        .first_feature  (first_feature),
        .second_feature (second_feature),
        .feature_value  (feature_value),
        .threshold      (threshold),
        .bin            (bin),
        .entry_slot     (entry_slot),
        .coef_index     (coef_index),
        .coef_value     (coef_value),
        .list_length    (list_length),
        .done           (done),
        .bin_index      (bin_index),
        .read_value     (read_value),
        .saturated      (saturated)
    );

    always #5 clk = ~clk;

    function automatic logic [BIN_OUT_W-1:0] fern_bin();
        logic [BIN_OUT_W-1:0] b;
        int n;
        longint d;
        b = '0;
        n = (tests_cfg > N_TESTS) ? N_TESTS : tests_cfg;
        for (int i = 0; i < n; i++)
        begin
            d = longint'(feat_mem[test_a[i]]) - longint'(feat_mem[test_b[i]]);
            if (d > longint'(thr_mem[i]))
                b[i] = 1'b1;
        end
        return b;
    endfunction

    // Update the fern stores for one beat and return its result.
    function automatic fern_res_t fern_outcome(fern_cmd_t c);
        fern_res_t r;
        logic [BIN_OUT_W-1:0] b;
        int base;
        longint s;
        r = '{default: '0};
        case (c.mode)
            MODE_FEATURE: feat_mem[c.fa] = c.fval;
            MODE_TEST:
                if (c.slot < N_TESTS)
                begin
                    test_a[c.slot]  = c.fa;
                    test_b[c.slot]  = c.fb;
                    thr_mem[c.slot] = c.thr;
                end
            MODE_ENTRY:
            begin
                ent_idx[{c.bin, c.eslot}]   = c.ci;
                ent_delta[{c.bin, c.eslot}] = c.cval;
            end
            MODE_LENGTH: len_mem[c.bin] = (c.len > N_ENTRIES) ? LEN_IN_W'(N_ENTRIES) : c.len;
            MODE_COEF_WR: coef_mem[c.ci] = c.cval;
            MODE_APPLY:
            begin
                b = fern_bin();
                base = b * N_ENTRIES;
                for (int k = 0; k < len_mem[b]; k++)
                begin
                    s = longint'(coef_mem[ent_idx[base+k]]) + longint'(ent_delta[base+k]);
                    if (s > longint'(COEF_MAX))
                    begin
                        s = longint'(COEF_MAX);
                        r.saturated = 1'b1;
                    end
                    if (s < longint'(COEF_MIN))
                    begin
                        s = longint'(COEF_MIN);
                        r.saturated = 1'b1;
                    end
                    coef_mem[ent_idx[base+k]] = s[COEF_W-1:0];
                end
                r.bin_index = b;
            end
            MODE_COEF_RD: r.read_value = coef_mem[c.ci];
            default: ;
        endcase
        return r;
    endfunction

    function automatic fern_cmd_t noise_cmd(logic [MODE_W-1:0] m);
        fern_cmd_t c;
        c.mode  = m;
        c.slot  = SLOT_W'($urandom);
        c.fa    = FADDR_W'($urandom);
        c.fb    = FADDR_W'($urandom);
        c.fval  = FEAT_W'($urandom);
        c.thr   = THR_W'($urandom);
        c.bin   = BIN_IN_W'($urandom);
        c.eslot = ESLOT_W'($urandom);
        c.ci    = CIDX_W'($urandom);
        c.cval  = COEF_W'($urandom);
        c.len   = LEN_IN_W'($urandom);
        return c;
    endfunction

    function automatic fern_cmd_t feature_cmd(logic [FADDR_W-1:0] a, logic signed [FEAT_W-1:0] v);
        fern_cmd_t c;
        c = noise_cmd(MODE_FEATURE);
        c.fa   = a;
        c.fval = v;
        return c;
    endfunction

    function automatic fern_cmd_t test_cmd(logic [SLOT_W-1:0] s, logic [FADDR_W-1:0] a,
                                           logic [FADDR_W-1:0] b, logic signed [THR_W-1:0] t);
        fern_cmd_t c;
        c = noise_cmd(MODE_TEST);
        c.slot = s;
        c.fa   = a;
        c.fb   = b;
        c.thr  = t;
        return c;
    endfunction

    function automatic fern_cmd_t entry_cmd(logic [BIN_IN_W-1:0] b, logic [ESLOT_W-1:0] s,
                                            logic [CIDX_W-1:0] i, logic signed [COEF_W-1:0] v);
        fern_cmd_t c;
        c = noise_cmd(MODE_ENTRY);
        c.bin   = b;
        c.eslot = s;
        c.ci    = i;
        c.cval  = v;
        return c;
    endfunction

    function automatic fern_cmd_t length_cmd(logic [BIN_IN_W-1:0] b, logic [LEN_IN_W-1:0] n);
        fern_cmd_t c;
        c = noise_cmd(MODE_LENGTH);
        c.bin = b;
        c.len = n;
        return c;
    endfunction

    function automatic fern_cmd_t coef_cmd(logic [MODE_W-1:0] m, logic [CIDX_W-1:0] i,
                                           logic signed [COEF_W-1:0] v);
        fern_cmd_t c;
        c = noise_cmd(m);
        c.ci   = i;
        c.cval = v;
        return c;
    endfunction

    function automatic table_row_t beat_row(fern_cmd_t c, bit typed, logic [BIN_OUT_W-1:0] b,
                                            logic signed [COEF_W-1:0] v, logic s);
        table_row_t r;
        r.is_cfg = 1'b0;
        r.cfg    = '0;
        r.cmd    = c;
        r.typed  = typed;
        r.res    = '{b, v, s};
        return r;
    endfunction

    function automatic table_row_t cfg_row(logic [CFG_W-1:0] v);
        table_row_t r;
        r = beat_row(noise_cmd(MODE_UNUSED), 1'b0, '0, '0, 1'b0);
        r.is_cfg = 1'b1;
        r.cfg    = v;
        return r;
    endfunction

    // Length of the run of written entries from slot 0 of a bin
    function automatic int filled(logic [BIN_IN_W-1:0] b);
        int k;
        k = 0;
        while (k < N_ENTRIES && ent_wr[{b, ESLOT_W'(k)}])
            k++;
        return k;
    endfunction

    function automatic logic [FADDR_W-1:0] pick_feature();
        return ($urandom_range(0, 9) < 7) ? FADDR_W'($urandom_range(0, 15)) : FADDR_W'($urandom);
    endfunction

    function automatic logic [CIDX_W-1:0] pick_coef();
        return ($urandom_range(0, 9) < 6) ? CIDX_W'($urandom_range(0, 15)) : CIDX_W'($urandom);
    endfunction

    function automatic logic signed [FEAT_W-1:0] rand_feature();
        case ($urandom_range(0, 9))
            0: return {1'b0, {(FEAT_W-1){1'b1}}};
            1: return {1'b1, {(FEAT_W-1){1'b0}}};
            default: return FEAT_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [THR_W-1:0] rand_threshold();
        if ($urandom_range(0, 9) < 3)
            return THR_W'($urandom);
        return THR_W'($urandom_range(0, 8191)) - THR_W'(4096);
    endfunction

    function automatic logic signed [COEF_W-1:0] rand_coef();
        case ($urandom_range(0, 3))
            0: return COEF_MAX - COEF_W'($urandom_range(0, 1 << 18));
            1: return COEF_MIN + COEF_W'($urandom_range(0, 1 << 18));
            2: return COEF_W'($urandom_range(0, 1 << 20)) - COEF_W'(1 << 19);
            default: return COEF_W'($urandom);
        endcase
    endfunction

    // Draw a beat; an apply that would read an unwritten test or feature
    // turns into the write that it is missing.
    function automatic fern_cmd_t random_cmd();
        int pick;
        int n;
        logic [BIN_IN_W-1:0] b;
        fern_cmd_t c;
        pick = $urandom_range(0, 99);
        b = ($urandom_range(0, 1) == 1) ? fern_bin() : BIN_IN_W'($urandom);
        if (pick < 14)
            c = feature_cmd(pick_feature(), rand_feature());
        else if (pick < 24)
            c = test_cmd(($urandom_range(0, 9) == 0) ? SLOT_W'($urandom_range(N_TESTS, 7))
                                                     : SLOT_W'($urandom_range(0, N_TESTS-1)),
                         pick_feature(), pick_feature(), rand_threshold());
        else if (pick < 44)
            c = entry_cmd(b, ($urandom_range(0, 3) != 0 && filled(b) < N_ENTRIES)
                             ? ESLOT_W'(filled(b)) : ESLOT_W'($urandom),
                          pick_coef(), rand_coef());
        else if (pick < 54)
        begin
            n = $urandom_range(0, 31);
            if (((n > N_ENTRIES) ? N_ENTRIES : n) > filled(b))
                n = filled(b);
            c = length_cmd(b, LEN_IN_W'(n));
        end
        else if (pick < 62)
            c = coef_cmd(MODE_COEF_WR, pick_coef(), rand_coef());
        else if (pick < 86)
        begin
            c = noise_cmd(MODE_APPLY);
            n = (tests_cfg > N_TESTS) ? N_TESTS : tests_cfg;
            for (int i = 0; i < n; i++)
            begin
                if (!test_wr[i])
                    return test_cmd(SLOT_W'(i), pick_feature(), pick_feature(),
                                    rand_threshold());
                if (!feat_wr[test_a[i]])
                    return feature_cmd(test_a[i], rand_feature());
                if (!feat_wr[test_b[i]])
                    return feature_cmd(test_b[i], rand_feature());
            end
        end
        else if (pick < 96)
            c = coef_cmd(MODE_COEF_RD, pick_coef(), rand_coef());
        else
            c = noise_cmd(MODE_UNUSED);
        return c;
    endfunction

    // Append one row to the stimulus table.
    task automatic add_step(input table_row_t r);
        steps.insert(steps.size(), r);
    endtask

    // Present one beat after a gap and hold it until the block takes it.
    task automatic send(input fern_cmd_t c, input bit typed, input fern_res_t want,
                        input int gap);
        fern_res_t got;
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start          <= 1'b1;
        mode           <= c.mode;
        test_slot      <= c.slot;
        first_feature  <= c.fa;
        second_feature <= c.fb;
        feature_value  <= c.fval;
        threshold      <= c.thr;
        bin            <= c.bin;
        entry_slot     <= c.eslot;
        coef_index     <= c.ci;
        coef_value     <= c.cval;
        list_length    <= c.len;
        do
            @(posedge clk);
        while (busy);
        got = fern_outcome(c);
        results_due.insert(results_due.size(), typed ? want : got);
        case (c.mode)
            MODE_FEATURE: feat_wr[c.fa] = 1'b1;
            MODE_TEST: if (c.slot < N_TESTS) test_wr[c.slot] = 1'b1;
            MODE_ENTRY: ent_wr[{c.bin, c.eslot}] = 1'b1;
            default: ;
        endcase
    endtask

    // Write tests_in_use once the block has drained.
    task automatic set_tests(input logic [CFG_W-1:0] v);
        @(negedge clk);
        start <= 1'b0;
        while (results_due.size() != 0 || busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= v;
        tests_cfg = v;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (results_due.size() == 0)
            begin
                errors++;
                $display("%0t: result with none expected: bin_index %0d read_value %0d saturated %0d",
                         $time, bin_index, read_value, saturated);
            end
            else
            begin
                oldest_due = results_due.pop_front();
                if (bin_index !== oldest_due.bin_index)
                begin
                    errors++;
                    $display("%0t: bin_index expected %0d actual %0d",
                             $time, oldest_due.bin_index, bin_index);
                end
                if (read_value !== oldest_due.read_value)
                begin
                    errors++;
                    $display("%0t: read_value expected %0d actual %0d",
                             $time, oldest_due.read_value, read_value);
                end
                if (saturated !== oldest_due.saturated)
                begin
                    errors++;
                    $display("%0t: saturated expected %0d actual %0d",
                             $time, oldest_due.saturated, saturated);
                end
            end
        end
    end

    // Watchdog: count cycles in which no beat moves either way
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [CFG_W-1:0] phase_cfg [8];
        fern_cmd_t c;
        int counted;
        int beats;
        bit calm;

        rst_n          <= 1'b0;
        cfg_write      <= 1'b0;
        cfg_data       <= '0;
        start          <= 1'b0;
        mode           <= '0;
        test_slot      <= '0;
        first_feature  <= '0;
        second_feature <= '0;
        feature_value  <= '0;
        threshold      <= '0;
        bin            <= '0;
        entry_slot     <= '0;
        coef_index     <= '0;
        coef_value     <= '0;
        list_length    <= '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Tests 1, 2 and 4 pass with the extreme features below: five tests select bin 22.
        add_step(beat_row(coef_cmd(MODE_COEF_RD, 8'd0, '0), 1'b1, '0, '0, 1'b0));
        add_step(beat_row(coef_cmd(MODE_COEF_RD, 8'd255, '0), 1'b1, '0, '0, 1'b0));
        add_step(beat_row('{MODE_UNUSED, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1},
                          1'b1, '0, '0, 1'b0));
        add_step(cfg_row(3'd0));
        add_step(beat_row(noise_cmd(MODE_APPLY), 1'b1, '0, '0, 1'b0));
        add_step(beat_row(feature_cmd(9'd0, 16'sh7FFF), 1'b1, '0, '0, 1'b0));
        add_step(beat_row(feature_cmd(9'd511, 16'sh8000), 1'b1, '0, '0, 1'b0));
        add_step(beat_row(test_cmd(3'd0, 9'd0, 9'd511, 17'sd65535), 1'b1, '0, '0, 1'b0));
        add_step(beat_row(test_cmd(3'd1, 9'd0, 9'd511, -17'sd65536), 1'b1, '0, '0, 1'b0));
        add_step(beat_row(test_cmd(3'd2, 9'd511, 9'd0, -17'sd65536), 1'b1, '0, '0, 1'b0));
        add_step(beat_row(test_cmd(3'd3, 9'd0, 9'd0, 17'sd0), 1'b1, '0, '0, 1'b0));
        add_step(beat_row(test_cmd(3'd4, 9'd511, 9'd511, -17'sd1), 1'b1, '0, '0, 1'b0));
        add_step(beat_row(test_cmd(3'd7, 9'd511, 9'd0, 17'sd0), 1'b1, '0, '0, 1'b0));
        add_step(beat_row(coef_cmd(MODE_COEF_WR, 8'd255, COEF_MAX), 1'b1, '0, '0, 1'b0));
        add_step(beat_row(coef_cmd(MODE_COEF_WR, 8'd0, COEF_MIN), 1'b1, '0, '0, 1'b0));
        add_step(beat_row(entry_cmd(5'd22, 4'd0, 8'd255, 32'sd1), 1'b1, '0, '0, 1'b0));
        add_step(beat_row(entry_cmd(5'd22, 4'd1, 8'd0, -32'sd1), 1'b1, '0, '0, 1'b0));
        add_step(beat_row(entry_cmd(5'd31, 4'd15, 8'd1, COEF_MAX), 1'b1, '0, '0, 1'b0));
        add_step(beat_row(length_cmd(5'd22, 5'd2), 1'b1, '0, '0, 1'b0));
        add_step(cfg_row(3'd7));
        add_step(beat_row(noise_cmd(MODE_APPLY), 1'b1, 5'd22, '0, 1'b1));
        add_step(beat_row(coef_cmd(MODE_COEF_RD, 8'd255, '0), 1'b1, '0, COEF_MAX, 1'b0));
        add_step(beat_row(coef_cmd(MODE_COEF_RD, 8'd0, '0), 1'b1, '0, COEF_MIN, 1'b0));
        add_step(cfg_row(3'd1));
        add_step(beat_row(noise_cmd(MODE_APPLY), 1'b1, 5'd0, '0, 1'b0));
        add_step(cfg_row(3'd6));
        add_step(beat_row(noise_cmd(MODE_APPLY), 1'b1, 5'd22, '0, 1'b1));
        add_step(beat_row(coef_cmd(MODE_COEF_RD, 8'd255, '0), 1'b0, '0, '0, 1'b0));

        foreach (steps[i])
        begin
            if (steps[i].is_cfg)
                set_tests(steps[i].cfg);
            else
                send(steps[i].cmd, steps[i].typed, steps[i].res, $urandom_range(0, 3));
        end

        phase_cfg = '{3'd5, 3'd1, 3'd0, 3'd7, 3'd3, 3'd2, 3'd6, 3'd4};
        beats = 0;
        calm = 1'b0;
        foreach (phase_cfg[p])
        begin
            set_tests(phase_cfg[p]);
            counted = 0;
            while (counted < PHASE_BEATS)
            begin
                // alternate stretches of back-to-back beats with gappy ones
                if (beats % 40 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                c = random_cmd();
                if (!(c.mode == MODE_UNUSED || (c.mode == MODE_TEST && c.slot >= N_TESTS)))
                    counted++;
                send(c, 1'b0, '{default: '0}, calm ? 0 : $urandom_range(0, 3));
                beats++;
            end
        end

        @(negedge clk);
        start <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
